// File: hw/rtl/ctb_pkg.sv
// ctb_pkg: shared constants, beat types and state codes for the countdown timer bank.
// Used by ctb_entry_ram, ctb_engine and countdown_timer_bank_top. No dependencies.
`default_nettype none

package ctb_pkg;

    // Sizing
    localparam int TIMERS      = 16;
    localparam int HANDLE_BITS = 8;
    localparam int IDX_W       = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W       = $clog2(TIMERS + 1);

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int ELAPSED_W = 16;
    localparam int DUR_W     = 32;
    localparam int REM_W     = DUR_W + 1;
    localparam int KIND_W    = 3;
    localparam int OHANDLE_W = 8;
    localparam int SCALED_W  = 24;
    localparam int TOTAL_W   = 48;
    localparam int SCALE_W   = 16;
    localparam int PROD_W    = ELAPSED_W + SCALE_W;
    localparam int FRAC_W    = 8;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_OK   = 3'd0,
        KIND_SET_FULL = 3'd1,
        KIND_CLEARED  = 3'd2,
        KIND_TICK     = 3'd3,
        KIND_FIRED    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_PACK
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [ELAPSED_W-1:0] elapsed;
        logic [DUR_W-1:0]     duration;
        logic                 repeat_req;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [OHANDLE_W-1:0] handle;
        logic [SCALED_W-1:0]  scaled_delta;
        logic [TOTAL_W-1:0]   total_time;
        logic                 last;
    } t_res;

    // remaining is two's complement; stored values are never negative
    typedef struct packed {
        logic [REM_W-1:0]       remaining;
        logic [DUR_W-1:0]       reload_value;
        logic                   repeats;
        logic [HANDLE_BITS-1:0] entry_handle;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: hw/rtl/ctb_entry_ram.sv
// ctb_entry_ram: timer entry store, one write and one registered read per cycle.
// Depends on ctb_pkg for t_entry, t_mem_req and TIMERS.
`default_nettype none

module ctb_entry_ram (
    input  wire logic              i_clk,
    input  wire ctb_pkg::t_mem_req i_req,
    output ctb_pkg::t_entry        o_rd_data
);

    ctb_pkg::t_entry mem [ctb_pkg::TIMERS];
    ctb_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hw/rtl/ctb_engine.sv
// ctb_engine: command sequencer; set/clear, tick walk over the entry RAM, list compaction.
// Depends on ctb_pkg; drives ctb_entry_ram through a t_mem_req bundle.
`default_nettype none

module ctb_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire ctb_pkg::t_cmd                 i_cmd,
    input  wire logic [ctb_pkg::SCALE_W-1:0]   i_time_scale,
    input  wire ctb_pkg::t_entry               i_rd_data,
    output ctb_pkg::t_mem_req                  o_mem_req,
    output logic                               o_busy,
    output logic                               o_res_stb,
    output ctb_pkg::t_res                      o_res
);

    ctb_pkg::t_state                      r_state, n_state;
    logic [ctb_pkg::CNT_W-1:0]            r_count, n_count;
    logic [ctb_pkg::HANDLE_BITS-1:0]      r_next_handle, n_next_handle;
    logic [ctb_pkg::TOTAL_W-1:0]          r_total, n_total;
    logic [ctb_pkg::ELAPSED_W-1:0]        r_elapsed, n_elapsed;
    logic [ctb_pkg::IDX_W-1:0]            r_idx, n_idx;
    logic [ctb_pkg::TIMERS-1:0]           r_keep, n_keep;
    logic                                 r_any_drop, n_any_drop;
    ctb_pkg::t_res                        r_pend, n_pend;
    ctb_pkg::t_res                        r_out, n_out;
    logic                                 r_out_stb, n_out_stb;
    logic [ctb_pkg::CNT_W-1:0]            r_src, n_src;
    logic [ctb_pkg::CNT_W-1:0]            r_dst, n_dst;
    logic                                 r_cp_vld, n_cp_vld;
    logic [ctb_pkg::IDX_W-1:0]            r_cp_idx, n_cp_idx;

    always_comb begin
        ctb_pkg::t_mem_req         req;
        ctb_pkg::t_res             res;
        logic [ctb_pkg::CNT_W-1:0] top_idx;
        logic [ctb_pkg::REM_W-1:0] rem_new;
        logic [ctb_pkg::PROD_W-1:0] prod;
        logic                      fire;
        logic                      drop;

        n_state       = r_state;
        n_count       = r_count;
        n_next_handle = r_next_handle;
        n_total       = r_total;
        n_elapsed     = r_elapsed;
        n_idx         = r_idx;
        n_keep        = r_keep;
        n_any_drop    = r_any_drop;
        n_pend        = r_pend;
        n_out         = r_out;
        n_out_stb     = 1'b0;
        n_src         = r_src;
        n_dst         = r_dst;
        n_cp_vld      = r_cp_vld;
        n_cp_idx      = r_cp_idx;

        req     = '0;
        res     = '0;
        top_idx = r_count - 1'b1;
        rem_new = i_rd_data.remaining - ctb_pkg::REM_W'(r_elapsed);
        fire    = rem_new[ctb_pkg::REM_W-1];
        drop    = fire && !i_rd_data.repeats;
        prod    = ctb_pkg::PROD_W'(i_cmd.elapsed) * ctb_pkg::PROD_W'(i_time_scale);

        unique case (r_state)
            ctb_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.opcode)
                        ctb_pkg::OP_SET: begin
                            if (r_count < ctb_pkg::CNT_W'(ctb_pkg::TIMERS)) begin
                                req.wr_en                  = 1'b1;
                                req.wr_addr                = r_count[ctb_pkg::IDX_W-1:0];
                                req.wr_data.remaining      = ctb_pkg::REM_W'(i_cmd.duration);
                                req.wr_data.reload_value   = i_cmd.duration;
                                req.wr_data.repeats        = i_cmd.repeat_req;
                                req.wr_data.entry_handle   = r_next_handle;
                                n_count       = r_count + 1'b1;
                                n_next_handle = r_next_handle + 1'b1;
                                res.kind      = ctb_pkg::KIND_SET_OK;
                                res.handle    = ctb_pkg::OHANDLE_W'(r_next_handle);
                            end else begin
                                res.kind      = ctb_pkg::KIND_SET_FULL;
                            end
                            res.last  = 1'b1;
                            n_out     = res;
                            n_out_stb = 1'b1;
                        end
                        ctb_pkg::OP_CLEAR: begin
                            n_count   = '0;
                            res.kind  = ctb_pkg::KIND_CLEARED;
                            res.last  = 1'b1;
                            n_out     = res;
                            n_out_stb = 1'b1;
                        end
                        ctb_pkg::OP_TICK: begin
                            n_total          = r_total + ctb_pkg::TOTAL_W'(i_cmd.elapsed);
                            n_elapsed        = i_cmd.elapsed;
                            res.kind         = ctb_pkg::KIND_TICK;
                            res.scaled_delta = prod[ctb_pkg::PROD_W-1:ctb_pkg::FRAC_W];
                            res.total_time   = n_total;
                            n_pend           = res;
                            n_any_drop       = 1'b0;
                            if (r_count == '0) begin
                                n_state = ctb_pkg::ST_FLUSH;
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = top_idx[ctb_pkg::IDX_W-1:0];
                                n_idx       = top_idx[ctb_pkg::IDX_W-1:0];
                                n_state     = ctb_pkg::ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ctb_pkg::ST_WALK: begin
                // entry r_idx is on the read port this cycle
                req.wr_en           = 1'b1;
                req.wr_addr         = r_idx;
                req.wr_data         = i_rd_data;
                req.wr_data.remaining = fire ? ctb_pkg::REM_W'(i_rd_data.reload_value)
                                             : rem_new;
                n_keep[r_idx] = !drop;
                if (drop) begin
                    n_any_drop = 1'b1;
                end
                if (fire) begin
                    n_out      = r_pend;
                    n_out_stb  = 1'b1;
                    res.kind   = ctb_pkg::KIND_FIRED;
                    res.handle = ctb_pkg::OHANDLE_W'(i_rd_data.entry_handle);
                    n_pend     = res;
                end
                if (r_idx != '0) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_idx - 1'b1;
                    n_idx       = r_idx - 1'b1;
                end else begin
                    n_state = ctb_pkg::ST_FLUSH;
                end
            end

            ctb_pkg::ST_FLUSH: begin
                n_out      = r_pend;
                n_out.last = 1'b1;
                n_out_stb  = 1'b1;
                if (r_any_drop) begin
                    n_src    = '0;
                    n_dst    = '0;
                    n_cp_vld = 1'b0;
                    n_state  = ctb_pkg::ST_PACK;
                end else begin
                    n_state = ctb_pkg::ST_IDLE;
                end
            end

            ctb_pkg::ST_PACK: begin
                // survivors move down in order; dst never passes the read side
                if (r_cp_vld && r_keep[r_cp_idx]) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = r_dst[ctb_pkg::IDX_W-1:0];
                    req.wr_data = i_rd_data;
                    n_dst       = r_dst + 1'b1;
                end
                if (r_src != r_count) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_src[ctb_pkg::IDX_W-1:0];
                    n_cp_idx    = r_src[ctb_pkg::IDX_W-1:0];
                    n_cp_vld    = 1'b1;
                    n_src       = r_src + 1'b1;
                end else begin
                    n_cp_vld = 1'b0;
                    if (!r_cp_vld) begin
                        n_count = r_dst;
                        n_state = ctb_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ctb_pkg::ST_IDLE;
            end
        endcase

        o_mem_req = req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ctb_pkg::ST_IDLE;
            r_count       <= '0;
            r_next_handle <= '0;
            r_total       <= '0;
            r_out_stb     <= 1'b0;
            r_any_drop    <= 1'b0;
            r_cp_vld      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_next_handle <= n_next_handle;
            r_total       <= n_total;
            r_out_stb     <= n_out_stb;
            r_any_drop    <= n_any_drop;
            r_cp_vld      <= n_cp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_idx     <= n_idx;
        r_keep    <= n_keep;
        r_pend    <= n_pend;
        r_out     <= n_out;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_cp_idx  <= n_cp_idx;
    end

    assign o_busy    = (r_state != ctb_pkg::ST_IDLE);
    assign o_res_stb = r_out_stb;
    assign o_res     = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/countdown_timer_bank_top.sv
// countdown_timer_bank_top: bank of countdown timers with auto reload, top level.
// Depends on ctb_pkg, ctb_entry_ram and ctb_engine.
//
//   channel   | beat type        | handshake
//   ----------+------------------+----------------------------------------
//   command   | ctb_pkg::t_cmd   | i_start, taken when o_busy is low
//   result    | ctb_pkg::t_res   | o_res_stb, one cycle per beat, no stall
//   config    | 16-bit scale     | i_cfg_we, written on that edge
//
// Set and clear: result beat in the cycle after the command.
// Tick: one RAM read-modify-write per live entry through the
// single-read-port entry RAM, plus a flush beat for the final result;
// when any one-shot timer expired, a compaction pass follows. o_busy is
// high throughout.
// Reset (synchronous, active low) empties the list; the entry RAM is not
// cleared since only entries below the live count are ever read.
// Result beats cannot be stalled; a fired timer beat is held one entry
// so the final beat of a command carries last.
`default_nettype none

module countdown_timer_bank_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire ctb_pkg::t_cmd               i_cmd,
    output logic                             o_busy,
    output logic                             o_res_stb,
    output ctb_pkg::t_res                    o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [ctb_pkg::SCALE_W-1:0] i_cfg_wdata
);

    // Q8.8 scale for the tick summary, 1.0 after reset
    logic [ctb_pkg::SCALE_W-1:0] r_time_scale;

    ctb_pkg::t_mem_req mem_req;
    ctb_pkg::t_entry   rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_scale <= ctb_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_time_scale <= i_cfg_wdata;
        end
    end

    ctb_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ctb_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_cmd        (i_cmd),
        .i_time_scale (r_time_scale),
        .i_rd_data    (rd_data),
        .o_mem_req    (mem_req),
        .o_busy       (o_busy),
        .o_res_stb    (o_res_stb),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

// File: tb/countdown_timer_bank_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for countdown_timer_bank_top: directed and random command beats,
// a per-command timer list predictor and a result checker. Depends on ctb_pkg and the DUT.

module countdown_timer_bank_top_tb;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 8;
    // settle time covers the worst tick and its compaction pass, plus margin
    localparam int SETTLE_CYCLES = 2 * ctb_pkg::TIMERS + 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    ctb_pkg::t_cmd                 i_cmd = '0;
    logic                          o_busy;
    logic                          o_res_stb;
    ctb_pkg::t_res                 o_res;
    logic                          i_cfg_we = 1'b0;
    logic [ctb_pkg::SCALE_W-1:0]   i_cfg_wdata = '0;

    countdown_timer_bank_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_res_stb   (o_res_stb),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Timer list model. Mirrors the list the block keeps: index 0 is the
    // oldest entry, tm_count-1 the newest. Updated when a command beat is
    // taken, so the expected result beats are queued before they appear.
    // ------------------------------------------------------------------
    logic signed [ctb_pkg::REM_W-1:0]  tm_left   [ctb_pkg::TIMERS];
    logic [ctb_pkg::DUR_W-1:0]         tm_reload [ctb_pkg::TIMERS];
    logic                              tm_rep    [ctb_pkg::TIMERS];
    logic [ctb_pkg::HANDLE_BITS-1:0]   tm_handle [ctb_pkg::TIMERS];
    int                                tm_count = 0;
    logic [ctb_pkg::HANDLE_BITS-1:0]   handle_next = '0;
    logic [ctb_pkg::TOTAL_W-1:0]       usec_total = '0;
    logic [ctb_pkg::SCALE_W-1:0]       scale_q8 = ctb_pkg::SCALE_RESET;

    ctb_pkg::t_res  expected_beats[$];   // result beats still owed by the block
    ctb_pkg::t_cmd  cmd_q[$];            // command beats not yet presented

    int errors = 0;
    int cmds_taken = 0;
    int beats_checked = 0;
    int fired_seen = 0;
    int full_seen = 0;
    int max_tick_beats = 0;
    int tick_beats = 0;

    int sender_idle_pct = 0;
    int burst_left = 0;

    function automatic void owe_beat(ctb_pkg::t_res b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic void add_cmd(ctb_pkg::t_cmd c);
        cmd_q = {cmd_q, c};
    endfunction

    function automatic void predict_cmd(ctb_pkg::t_cmd c);
        ctb_pkg::t_res                     r;
        ctb_pkg::t_res                     held;
        logic signed [ctb_pkg::REM_W-1:0]  left;
        logic [ctb_pkg::PROD_W-1:0]        prod;
        r = '0;
        case (c.opcode)
            ctb_pkg::OP_SET: begin
                if (tm_count < ctb_pkg::TIMERS) begin
                    tm_left[tm_count]   = ctb_pkg::REM_W'(c.duration);
                    tm_reload[tm_count] = c.duration;
                    tm_rep[tm_count]    = c.repeat_req;
                    tm_handle[tm_count] = handle_next;
                    tm_count++;
                    r.kind   = ctb_pkg::KIND_SET_OK;
                    r.handle = ctb_pkg::OHANDLE_W'(handle_next);
                    handle_next = handle_next + 1'b1;   // wraps at 2^HANDLE_BITS
                end else begin
                    // full list: nothing moves, handle counter holds
                    r.kind = ctb_pkg::KIND_SET_FULL;
                end
                r.last = 1'b1;
                owe_beat(r);
            end
            ctb_pkg::OP_CLEAR: begin
                // handle counter and running total survive a clear
                tm_count = 0;
                r.kind = ctb_pkg::KIND_CLEARED;
                r.last = 1'b1;
                owe_beat(r);
            end
            ctb_pkg::OP_TICK: begin
                usec_total = usec_total + ctb_pkg::TOTAL_W'(c.elapsed);
                prod = ctb_pkg::PROD_W'(c.elapsed) * ctb_pkg::PROD_W'(scale_q8);
                held = '0;
                held.kind         = ctb_pkg::KIND_TICK;
                held.scaled_delta = ctb_pkg::SCALED_W'(prod >> ctb_pkg::FRAC_W);
                held.total_time   = usec_total;
                // walk newest to oldest; each beat is pushed once the next
                // one is known so the final one can carry last
                for (int i = tm_count - 1; i >= 0; i--) begin
                    left = tm_left[i] - ctb_pkg::REM_W'(c.elapsed);
                    tm_left[i] = left;
                    if (left < 0) begin   // exactly zero waits for a later tick
                        owe_beat(held);
                        held = '0;
                        held.kind   = ctb_pkg::KIND_FIRED;
                        held.handle = ctb_pkg::OHANDLE_W'(tm_handle[i]);
                        if (tm_rep[i]) begin
                            tm_left[i] = ctb_pkg::REM_W'(tm_reload[i]);
                        end else begin
                            for (int j = i; j + 1 < tm_count; j++) begin
                                tm_left[j]   = tm_left[j + 1];
                                tm_reload[j] = tm_reload[j + 1];
                                tm_rep[j]    = tm_rep[j + 1];
                                tm_handle[j] = tm_handle[j + 1];
                            end
                            tm_count--;
                        end
                    end
                end
                held.last = 1'b1;
                owe_beat(held);
            end
            default: begin
                // unused opcode: no beats, no state change
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes beats from cmd_q, holds i_start/i_cmd until the block
    // takes them (start high with busy low at the edge). Each signal gets
    // exactly one NBA per edge so back-to-back beats never glitch.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : cmd_driver
        logic go;
        logic idle_now;
        ctb_pkg::t_cmd nxt;
        if (i_rst_n) begin
            go  = i_start;
            nxt = i_cmd;
            if (i_start && !o_busy) begin
                predict_cmd(i_cmd);
                cmds_taken++;
                go = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (burst_left == 0 && sender_idle_pct != 0 && $urandom_range(99) < 3) begin
                burst_left = $urandom_range(4, 12);   // short stretch with no gaps
            end
            idle_now = (burst_left == 0) && ($urandom_range(99) < sender_idle_pct);
            if (!go && cmd_q.size() > 0 && !idle_now) begin
                nxt = cmd_q.pop_front();
                go  = 1'b1;
            end
            i_start <= go;
            i_cmd   <= nxt;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed beat is compared against the oldest expected
    // beat. The receiver cannot stall, so sampling at the edge is all.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : res_monitor
        ctb_pkg::t_res want;
        if (i_rst_n && o_res_stb) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d handle %0d", o_res.kind, o_res.handle);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (o_res.kind != want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_res.kind);
                    errors++;
                end
                if (o_res.handle != want.handle) begin
                    $error("handle: expected %0d, actual %0d", want.handle, o_res.handle);
                    errors++;
                end
                if (o_res.scaled_delta != want.scaled_delta) begin
                    $error("scaled_delta: expected %0d, actual %0d",
                           want.scaled_delta, o_res.scaled_delta);
                    errors++;
                end
                if (o_res.total_time != want.total_time) begin
                    $error("total_time: expected %0d, actual %0d",
                           want.total_time, o_res.total_time);
                    errors++;
                end
                if (o_res.last != want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_res.last);
                    errors++;
                end
                if (want.kind == ctb_pkg::KIND_FIRED) begin
                    fired_seen++;
                end
                if (want.kind == ctb_pkg::KIND_SET_FULL) begin
                    full_seen++;
                end
                if (want.kind == ctb_pkg::KIND_TICK) begin
                    tick_beats = 1;
                end else if (want.kind == ctb_pkg::KIND_FIRED) begin
                    tick_beats++;
                end
                if (tick_beats > max_tick_beats) begin
                    max_tick_beats = tick_beats;
                end
            end
        end
    end

    // Watchdog
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, expected_beats.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic ctb_pkg::t_cmd mk_cmd(ctb_pkg::t_op op,
                                             logic [ctb_pkg::ELAPSED_W-1:0] el,
                                             logic [ctb_pkg::DUR_W-1:0] dur, logic rep);
        ctb_pkg::t_cmd c;
        c.opcode     = op;
        c.elapsed    = el;
        c.duration   = dur;
        c.repeat_req = rep;
        return c;
    endfunction

    // Block is idle once everything is presented, taken and answered; the
    // extra settle covers a tick whose last beat left before its compaction
    // pass finished, and an ignored opcode that owes no beats at all.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (cmd_q.size() != 0 || i_start || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_scale(logic [ctb_pkg::SCALE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scale_q8 = v;
    endtask

    // Mostly set/tick traffic with durations close to the tick sizes so
    // timers fire, reload and compact often; unused fields carry noise.
    task automatic queue_random(int n);
        int sel;
        logic [ctb_pkg::DUR_W-1:0] dur;
        logic [ctb_pkg::ELAPSED_W-1:0] el;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                case ($urandom_range(19))
                    0, 1, 2:    dur = $urandom();
                    3, 4, 5:    dur = $urandom_range(0, 3);
                    default:    dur = $urandom_range(0, 4000);
                endcase
                add_cmd(mk_cmd(ctb_pkg::OP_SET, ctb_pkg::ELAPSED_W'($urandom()), dur,
                               1'($urandom())));
            end else if (sel < 85) begin
                case ($urandom_range(9))
                    0:          el = '0;
                    1, 2:       el = ctb_pkg::ELAPSED_W'($urandom());
                    default:    el = ctb_pkg::ELAPSED_W'($urandom_range(0, 1500));
                endcase
                add_cmd(mk_cmd(ctb_pkg::OP_TICK, el, $urandom(), 1'($urandom())));
            end else if (sel < 93) begin
                add_cmd(mk_cmd(ctb_pkg::OP_CLEAR, ctb_pkg::ELAPSED_W'($urandom()),
                               $urandom(), 1'($urandom())));
            end else begin
                // ignored opcode; not counted toward n
                add_cmd(mk_cmd(ctb_pkg::OP_NONE, ctb_pkg::ELAPSED_W'($urandom()),
                               $urandom(), 1'($urandom())));
                k--;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, scale at its reset value of 1.0
        sender_idle_pct = 0;
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, '0, '0, 1'b0));          // empty list, zero step
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, '1, '1, 1'b1));          // empty list, largest step
        add_cmd(mk_cmd(ctb_pkg::OP_SET, '0, '0, 1'b0));           // one-shot, zero length
        add_cmd(mk_cmd(ctb_pkg::OP_SET, '0, '0, 1'b1));           // repeating, zero length
        add_cmd(mk_cmd(ctb_pkg::OP_SET, '0, 32'd100, 1'b0));
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, '0, '0, 1'b0));          // zero entries stay put
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, 16'd100, '0, 1'b0));     // one lands exactly on zero
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, 16'd1, '0, 1'b0));       // ... and fires a tick later
        // fill to capacity, overflow once, then fire every entry in one tick
        for (int k = 0; k < ctb_pkg::TIMERS - 1; k++) begin
            add_cmd(mk_cmd(ctb_pkg::OP_SET, '0, $urandom_range(0, 60000), 1'(k)));
        end
        add_cmd(mk_cmd(ctb_pkg::OP_SET, '1, '1, 1'b1));           // list full
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, '1, '0, 1'b0));
        add_cmd(mk_cmd(ctb_pkg::OP_NONE, '1, '1, 1'b1));          // ignored opcode
        add_cmd(mk_cmd(ctb_pkg::OP_CLEAR, '0, '0, 1'b0));
        wait_drained();

        // Zero scale, no idling
        write_scale('0);
        queue_random(20);
        wait_drained();

        // Largest scale, sender mostly idle
        write_scale('1);
        sender_idle_pct = 85;
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, '1, '0, 1'b0));          // widest scaled delta
        queue_random(20);
        wait_drained();

        // Random scale, light idling
        write_scale(ctb_pkg::SCALE_W'($urandom()));
        sender_idle_pct = 20;
        queue_random(20);
        wait_drained();

        // Back-to-back set burst at a 1.5 scale, then a tick and a clear
        write_scale(16'd384);
        sender_idle_pct = 0;
        for (int k = 0; k < ctb_pkg::TIMERS - 1; k++) begin
            add_cmd(mk_cmd(ctb_pkg::OP_SET, '0, $urandom_range(0, 200), 1'($urandom())));
        end
        add_cmd(mk_cmd(ctb_pkg::OP_TICK, ctb_pkg::ELAPSED_W'($urandom_range(0, 150)),
                       '0, 1'b0));
        add_cmd(mk_cmd(ctb_pkg::OP_CLEAR, '0, '0, 1'b0));
        wait_drained();

        if (expected_beats.size() != 0) begin
            $error("%0d expected beats never arrived", expected_beats.size());
            errors++;
        end
        $display("covered %0d commands, %0d result beats, %0d timer firings, %0d full rejects",
                 cmds_taken, beats_checked, fired_seen, full_seen);
        $display("longest tick answer %0d beats, handle counter now %0d, %0d errors",
                 max_tick_beats, handle_next, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
